FILE: rtl/nrlw_pkg.sv
package nrlw_pkg;

   // Table geometry
   localparam int RULE_DEPTH = 256;
   localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

   // Field widths
   localparam int IP_W    = 32;
   localparam int PORT_W  = 16;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = IP_W + PORT_W + KIND_W;

   // Request commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Key classes; the last code never matches anything
   localparam logic [KIND_W-1:0] KIND_EXACT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ANY_PORT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANY_ADDR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

   // Response status codes
   localparam logic [STAT_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MATCH    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_NO_MATCH = 2'd3;

   // Stored rule half: {ip, port, kind}
   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [KIND_W-1:0] kind;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_TGT,
      S_RESP
   } state_type;

endpackage

FILE: rtl/nrlw_if.sv
interface nrlw_req_if
   import nrlw_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [IP_W-1:0]   key_ip;
   logic [PORT_W-1:0] key_port;
   logic [KIND_W-1:0] key_kind;
   logic [IP_W-1:0]   xlate_ip;
   logic [PORT_W-1:0] xlate_port;
   logic [KIND_W-1:0] xlate_kind;

   modport source (
      output valid, cmd, key_ip, key_port, key_kind, xlate_ip, xlate_port, xlate_kind,
      input  ready
   );
   modport sink (
      input  valid, cmd, key_ip, key_port, key_kind, xlate_ip, xlate_port, xlate_kind,
      output ready
   );
endinterface

interface nrlw_rsp_if
   import nrlw_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [IP_W-1:0]   out_ip;
   logic [PORT_W-1:0] out_port;
   logic [KIND_W-1:0] out_kind;
   logic [KIND_W-1:0] matched_class;

   modport source (
      output valid, status, out_ip, out_port, out_kind, matched_class,
      input  ready
   );
   modport sink (
      input  valid, status, out_ip, out_port, out_kind, matched_class,
      output ready
   );
endinterface

FILE: rtl/nat_rule_lookup_wildcard_core.sv
// NAT rule table with wildcard classes. An insert request stores one rule
// (match key plus translation target) at the next free slot and answers
// "inserted", or "table full" once RULE_DEPTH rules are held. A lookup
// request scans the stored rules newest first through a single compare unit
// fed by the read port of the match memory, one rule per cycle, and records
// the newest hit of each class on the way. An exact query then picks exact
// over any-port over any-address; a wildcard query looks at its own class
// only; a query of the unused class, or one on an empty table, answers "no
// match" at once. A lookup that hits reads the match memory once per stored
// rule, compares the last read, settles the class and reads the target
// memory, then captures the target before the response; a lookup that
// misses skips the target read and capture. One request is in flight at a
// time: req_bus.ready is high only while idle, and the response is held
// until taken. Both rule memories need no clearing after reset; only slots
// below the rule count are ever read.
module nat_rule_lookup_wildcard_core
   import nrlw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   nrlw_req_if.sink   req_bus,
   nrlw_rsp_if.source rsp_bus
);

   // Sequencer
   state_type state_ff, state_in;

   // Rule count and latched query
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IP_W-1:0]   q_ip_ff, q_ip_in;
   logic [PORT_W-1:0] q_port_ff, q_port_in;
   logic [KIND_W-1:0] q_kind_ff, q_kind_in;

   // Scan pointer and read pipeline
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // Newest hit per class (exact, any port, any address)
   logic [2:0]       hit_vld_ff, hit_vld_in;
   logic [IDX_W-1:0] hit_idx_ff [3];
   logic [IDX_W-1:0] hit_idx_in [3];
   logic [KIND_W-1:0] sel_cls_ff, sel_cls_in;

   // Response register
   logic [STAT_W-1:0] status_ff, status_in;
   logic [IP_W-1:0]   oip_ff, oip_in;
   logic [PORT_W-1:0] oport_ff, oport_in;
   logic [KIND_W-1:0] okind_ff, okind_in;
   logic [KIND_W-1:0] ocls_ff, ocls_in;

   // Memory ports
   logic                 mem_we;
   logic                 scan_rd;
   logic                 tgt_rd;
   logic [ENTRY_W-1:0]   match_rdata;
   logic [ENTRY_W-1:0]   tgt_rdata;
   entry_type            match_wdata;
   entry_type            tgt_wdata;
   entry_type            cmp_entry;
   entry_type            tgt_entry;

   // Handshakes and decisions
   logic             req_fire;
   logic             rsp_fire;
   logic             scan_done;
   logic             found;
   logic [IDX_W-1:0] sel_idx;
   logic [KIND_W-1:0] sel_cls;
   logic             ip_eq;
   logic             port_eq;
   logic             cls_ok;
   logic             hit;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // ---------------------------------------------------------------
   // Rule memories: match key and translation target
   // ---------------------------------------------------------------
   assign match_wdata = '{ip: req_bus.key_ip, port: req_bus.key_port,
                          kind: req_bus.key_kind};
   assign tgt_wdata   = '{ip: req_bus.xlate_ip, port: req_bus.xlate_port,
                          kind: req_bus.xlate_kind};

   nrlw_ram #(.WIDTH(ENTRY_W), .DEPTH(RULE_DEPTH)) u_match_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (match_wdata),
      .rd_en   (scan_rd),
      .rd_addr (ptr_ff),
      .rd_data (match_rdata)
   );

   nrlw_ram #(.WIDTH(ENTRY_W), .DEPTH(RULE_DEPTH)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (tgt_wdata),
      .rd_en   (tgt_rd),
      .rd_addr (sel_idx),
      .rd_data (tgt_rdata)
   );

   assign cmp_entry = entry_type'(match_rdata);
   assign tgt_entry = entry_type'(tgt_rdata);

   // ---------------------------------------------------------------
   // Shared compare unit: one stored key per cycle
   // ---------------------------------------------------------------
   assign ip_eq   = (cmp_entry.ip == q_ip_ff);
   assign port_eq = (cmp_entry.port == q_port_ff);
   // exact query looks at every class, a wildcard query at its own only
   assign cls_ok  = (q_kind_ff == KIND_EXACT) || (cmp_entry.kind == q_kind_ff);

   always_comb begin
      case (cmp_entry.kind)
         KIND_EXACT:    hit = ip_eq && port_eq;
         KIND_ANY_PORT: hit = ip_eq;
         KIND_ANY_ADDR: hit = port_eq;
         default:       hit = 1'b0;
      endcase
      hit = hit && cls_ok && cmp_vld_ff;
   end

   // Class priority once the scan has drained
   assign scan_done = (state_ff == S_SCAN) && (left_ff == '0) && !cmp_vld_ff;
   assign found     = |hit_vld_ff;

   always_comb begin
      if (hit_vld_ff[KIND_EXACT]) begin
         sel_cls = KIND_EXACT;
         sel_idx = hit_idx_ff[KIND_EXACT];
      end else if (hit_vld_ff[KIND_ANY_PORT]) begin
         sel_cls = KIND_ANY_PORT;
         sel_idx = hit_idx_ff[KIND_ANY_PORT];
      end else begin
         sel_cls = KIND_ANY_ADDR;
         sel_idx = hit_idx_ff[KIND_ANY_ADDR];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.cmd == CMD_INSERT || cnt_ff == '0 ||
                   req_bus.key_kind == KIND_UNUSED) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = found ? S_TGT : S_RESP;
            end
         end
         S_TGT:  state_in = S_RESP;
         S_RESP: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      scan_rd       = 1'b0;
      tgt_rd        = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            mem_we = req_bus.valid && (req_bus.cmd == CMD_INSERT) &&
                     (cnt_ff != CNT_W'(RULE_DEPTH));
         end
         S_SCAN: begin
            scan_rd = (left_ff != '0);
            tgt_rd  = scan_done && found;
         end
         S_TGT:  ;
         S_RESP: rsp_bus.valid = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in     = cnt_ff;
      q_ip_in    = q_ip_ff;
      q_port_in  = q_port_ff;
      q_kind_in  = q_kind_ff;
      left_in    = left_ff;
      ptr_in     = ptr_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      hit_vld_in = hit_vld_ff;
      hit_idx_in = hit_idx_ff;
      sel_cls_in = sel_cls_ff;
      status_in  = status_ff;
      oip_in     = oip_ff;
      oport_in   = oport_ff;
      okind_in   = okind_ff;
      ocls_in    = ocls_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               q_ip_in    = req_bus.key_ip;
               q_port_in  = req_bus.key_port;
               q_kind_in  = req_bus.key_kind;
               left_in    = cnt_ff;
               ptr_in     = IDX_W'(cnt_ff - CNT_W'(1));
               hit_vld_in = '0;
               oip_in     = '0;
               oport_in   = '0;
               okind_in   = '0;
               ocls_in    = '0;
               if (req_bus.cmd == CMD_INSERT) begin
                  if (cnt_ff == CNT_W'(RULE_DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_INSERTED;
                     cnt_in    = cnt_ff + CNT_W'(1);
                  end
               end else begin
                  status_in = STATUS_NO_MATCH;
               end
            end
         end
         S_SCAN: begin
            if (left_ff != '0) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = ptr_ff;
               ptr_in     = ptr_ff - IDX_W'(1);
               left_in    = left_ff - CNT_W'(1);
            end
            // first hit per class seen newest first is the one to keep
            if (hit) begin
               case (cmp_entry.kind)
                  KIND_EXACT: begin
                     if (!hit_vld_ff[KIND_EXACT]) begin
                        hit_vld_in[KIND_EXACT] = 1'b1;
                        hit_idx_in[KIND_EXACT] = cmp_idx_ff;
                     end
                  end
                  KIND_ANY_PORT: begin
                     if (!hit_vld_ff[KIND_ANY_PORT]) begin
                        hit_vld_in[KIND_ANY_PORT] = 1'b1;
                        hit_idx_in[KIND_ANY_PORT] = cmp_idx_ff;
                     end
                  end
                  KIND_ANY_ADDR: begin
                     if (!hit_vld_ff[KIND_ANY_ADDR]) begin
                        hit_vld_in[KIND_ANY_ADDR] = 1'b1;
                        hit_idx_in[KIND_ANY_ADDR] = cmp_idx_ff;
                     end
                  end
                  default: ;
               endcase
            end
            if (scan_done) begin
               sel_cls_in = sel_cls;
            end
         end
         S_TGT: begin
            status_in = STATUS_MATCH;
            oip_in    = tgt_entry.ip;
            oport_in  = tgt_entry.port;
            okind_in  = tgt_entry.kind;
            ocls_in   = sel_cls_ff;
         end
         S_RESP: ;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_vld_ff <= hit_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ip_ff    <= q_ip_in;
      q_port_ff  <= q_port_in;
      q_kind_ff  <= q_kind_in;
      left_ff    <= left_in;
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_idx_ff <= hit_idx_in;
      sel_cls_ff <= sel_cls_in;
      status_ff  <= status_in;
      oip_ff     <= oip_in;
      oport_ff   <= oport_in;
      okind_ff   <= okind_in;
      ocls_ff    <= ocls_in;
   end

   assign rsp_bus.status        = status_ff;
   assign rsp_bus.out_ip        = oip_ff;
   assign rsp_bus.out_port      = oport_ff;
   assign rsp_bus.out_kind      = okind_ff;
   assign rsp_bus.matched_class = ocls_ff;

endmodule

FILE: rtl/nrlw_ram.sv
// Simple dual-port RAM, registered read.
module nrlw_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/nrlw_checker.sv
module nrlw_checker
   import nrlw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic [IP_W-1:0]   rsp_out_ip,
   input logic [PORT_W-1:0] rsp_out_port,
   input logic [KIND_W-1:0] rsp_out_kind,
   input logic [KIND_W-1:0] rsp_matched_class
);

   // one request in flight: no new request while a response waits
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // an accepted request has the input side closed in the cycle after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open right after acceptance");

   // only a match carries translation data
   a_zero_unless_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_MATCH) |->
         (rsp_out_ip == '0 && rsp_out_port == '0 && rsp_out_kind == '0 &&
          rsp_matched_class == '0))
      else $error("non-match response carries data");

   a_match_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_MATCH) |-> (rsp_matched_class != KIND_UNUSED))
      else $error("match reported in the unused class");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_out_ip)))
      else $error("stalled response changed");

endmodule

bind nat_rule_lookup_wildcard_core nrlw_checker u_nrlw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_out_ip        (rsp_bus.out_ip),
   .rsp_out_port      (rsp_bus.out_port),
   .rsp_out_kind      (rsp_bus.out_kind),
   .rsp_matched_class (rsp_bus.matched_class)
);
